/* sv/rit_pkg.sv */
// ----------------------------------------------------------------------------
// rit_pkg
// Types and codes shared by the region interval table and its cells.
// ----------------------------------------------------------------------------
package rit_pkg;

  localparam int ADDR_W  = 39;
  localparam int FLAG_W  = 4;
  localparam int COUNT_W = 5;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RANGE = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [FLAG_W-1:0] range_flags;
    logic [ADDR_W-1:0] lookup_address;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  hit_start;
    logic [ADDR_W-1:0]  hit_end;
    logic [FLAG_W-1:0]  hit_flags;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  // result wave passed from cell to cell
  typedef struct packed {
    logic   overlap;
    logic   found;
    entry_t hit;
  } carry_t;

endpackage

/* sv/region_interval_table.sv */
// ----------------------------------------------------------------------------
// region_interval_table
// Sorted table of half-open address ranges with a one-entry find cache.
// ----------------------------------------------------------------------------
// A request is accepted only in the idle state, after the previous one has
// reached the response register. The result wave crosses the cell chain
// one cell per cycle.
// The response register frees the request side while a response waits.
// Reset: synchronous; empties the table and the cache, no clearing pass.
module region_interval_table #(
  parameter int MAX_RANGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rit_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rit_pkg::rsp_t rsp
);
  import rit_pkg::*;

  localparam int CW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNW = $clog2(MAX_RANGES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t         state;
  logic [CW-1:0]  scan_cnt;
  req_t           key;
  logic [CNW-1:0] count;
  logic [CNW-1:0] count_next;
  logic           cache_valid;
  entry_t         cache;

  logic           le       [MAX_RANGES];
  entry_t         entries  [MAX_RANGES];
  carry_t         carries  [MAX_RANGES];
  logic           shift;
  logic           commit;
  logic           cache_hit;
  logic           cache_load;
  logic           cache_clear;
  rsp_t           rsp_next;
  carry_t         last;

  assign req_ready = (state == S_IDLE);
  assign last      = carries[MAX_RANGES-1];
  assign commit    = (state == S_DONE) && (!rsp_valid || rsp_ready);

  genvar k;
  generate
    for (k = 0; k < MAX_RANGES; k++) begin : g_cell
      logic   occupied;
      logic   le_prev;
      logic   le_next;
      entry_t prev_entry;
      carry_t carry_in;

      assign occupied = (count > CNW'(k));
      if (k == 0) begin : g_first
        assign le_prev    = 1'b1;
        assign prev_entry = '{base: key.range_start, limit: key.range_end,
                              flags: key.range_flags};
        assign carry_in   = '0;
      end else begin : g_rest
        assign le_prev    = le[k-1];
        assign prev_entry = entries[k-1];
        assign carry_in   = carries[k-1];
      end
      if (k == MAX_RANGES - 1) begin : g_last
        assign le_next = 1'b0;
      end else begin : g_mid
        assign le_next = le[k+1];
      end

      rit_cell u_cell (
        .clk        (clk),
        .key        (key),
        .occupied   (occupied),
        .le_prev    (le_prev),
        .le_next    (le_next),
        .shift      (shift),
        .prev_entry (prev_entry),
        .carry_in   (carry_in),
        .le         (le[k]),
        .entry      (entries[k]),
        .carry_out  (carries[k])
      );
    end
  endgenerate

  assign cache_hit = cache_valid && (cache.base <= key.lookup_address) &&
                     (key.lookup_address < cache.limit);

  always_comb begin
    rsp_next    = '0;
    rsp_next.status = ST_OK;
    count_next  = count;
    shift       = 1'b0;
    cache_load  = 1'b0;
    cache_clear = 1'b0;
    case (key.command)
      CMD_CLEAR: begin
        count_next  = '0;
        cache_clear = 1'b1;
      end
      CMD_INSERT: begin
        if (key.range_start >= key.range_end) begin
          rsp_next.status = ST_BAD_RANGE;
        end else if (last.overlap) begin
          rsp_next.status = ST_OVERLAP;
        end else if (count >= CNW'(MAX_RANGES)) begin
          rsp_next.status = ST_FULL;
        end else begin
          shift      = commit;
          count_next = count + CNW'(1);
        end
      end
      CMD_FIND: begin
        if (cache_hit) begin
          rsp_next.hit_start = cache.base;
          rsp_next.hit_end   = cache.limit;
          rsp_next.hit_flags = cache.flags;
        end else if (last.found) begin
          cache_load         = 1'b1;
          rsp_next.hit_start = last.hit.base;
          rsp_next.hit_end   = last.hit.limit;
          rsp_next.hit_flags = last.hit.flags;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_cnt    <= '0;
      count       <= '0;
      cache_valid <= 1'b0;
      cache       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
          end
        end
        S_SCAN: begin
          if (scan_cnt == CW'(MAX_RANGES - 1)) begin
            state <= S_DONE;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        S_DONE: begin
          if (commit) begin
            state     <= S_IDLE;
            count     <= count_next;
            if (cache_clear) begin
              cache_valid <= 1'b0;
              cache       <= '0;
            end else if (cache_load) begin
              cache_valid <= 1'b1;
              cache       <= last.hit;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      key <= req;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNW'(MAX_RANGES))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> count == CNW'(MAX_RANGES))
    else $error("table full reported while not full");

  a_hit_cached: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.hit_end != '0) |-> cache_valid)
    else $error("find hit without a valid cache");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    commit && (key.command == CMD_INSERT) && (rsp_next.status != ST_OK)
    |=> count == $past(count))
    else $error("rejected insert changed the table");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> (state == S_SCAN) && (scan_cnt == '0))
    else $error("accepted item did not start a scan");

endmodule

/* sv/rit_cell.sv */
// ----------------------------------------------------------------------------
// rit_cell
// One table slot: holds a range, compares it with the request, folds its
// findings into the result wave and shifts up on an insert.
// ----------------------------------------------------------------------------
module rit_cell (
  input  logic            clk,
  input  rit_pkg::req_t   key,
  input  logic            occupied,
  input  logic            le_prev,
  input  logic            le_next,
  input  logic            shift,
  input  rit_pkg::entry_t prev_entry,
  input  rit_pkg::carry_t carry_in,
  output logic            le,
  output rit_pkg::entry_t entry,
  output rit_pkg::carry_t carry_out
);
  import rit_pkg::*;

  logic   match;
  logic   pred_ovl;
  logic   succ_ovl;
  entry_t new_entry;

  assign new_entry = '{base: key.range_start, limit: key.range_end, flags: key.range_flags};

  // slot starts at or below the new start: new range goes after it
  assign le = occupied && (entry.base <= key.range_start);

  assign match = occupied && (entry.base <= key.lookup_address) &&
                 (key.lookup_address < entry.limit);

  // last slot before the insert point
  assign pred_ovl = le && !le_next && (entry.limit > key.range_start);
  // first slot after the insert point
  assign succ_ovl = occupied && !le && le_prev && (key.range_end > entry.base);

  always_ff @(posedge clk) begin
    if (shift && !le) begin
      entry <= le_prev ? new_entry : prev_entry;
    end
    carry_out.overlap <= carry_in.overlap || pred_ovl || succ_ovl;
    carry_out.found   <= carry_in.found || match;
    carry_out.hit     <= match ? entry : carry_in.hit;
  end

endmodule

/* tb/sv/region_interval_table_test.sv */
// ----------------------------------------------------------------------------
// region_interval_table_test
// Self-checking bench for the sorted address range table. A queue of
// commands, directed first and then random sessions and noise, feeds a driver
// on the request channel. Every accepted command is run through a local
// model of the table and its find cache. Each response is checked field by
// field against the oldest expected one. Both channels idle at random, the
// response side holds off once for a long stretch, and the sender at times
// pauses until every expected response has come back.
// ----------------------------------------------------------------------------
module region_interval_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rit_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 1250;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  region_interval_table #(.MAX_RANGES(TABLE_DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  bit   pending_drain[$];
  rsp_t expected_rsps[$];

  int n_issued = 0;
  int n_acc = 0;
  int fails = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit drv_valid;
  req_t drv_item;

  // table model
  logic [ADDR_W-1:0] tab_base  [TABLE_DEPTH];
  logic [ADDR_W-1:0] tab_limit [TABLE_DEPTH];
  logic [FLAG_W-1:0] tab_flags [TABLE_DEPTH];
  int held = 0;
  bit cache_v = 1'b0;
  logic [ADDR_W-1:0] cache_base = '0;
  logic [ADDR_W-1:0] cache_limit = '0;
  logic [FLAG_W-1:0] cache_flags = '0;

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int pos;
    int k;
    bit hit;
    o = '0;
    o.status = ST_OK;
    case (r.command)
      CMD_CLEAR: begin
        held = 0;
        cache_v = 1'b0;
        cache_base = '0;
        cache_limit = '0;
        cache_flags = '0;
      end
      CMD_INSERT: begin
        if (r.range_start >= r.range_end) begin
          o.status = ST_BAD_RANGE;
        end else begin
          pos = 0;
          while (pos < held && tab_base[pos] <= r.range_start) pos++;
          if (pos > 0 && tab_limit[pos-1] > r.range_start) begin
            o.status = ST_OVERLAP;
          end else if (pos < held && r.range_end > tab_base[pos]) begin
            o.status = ST_OVERLAP;
          end else if (held >= TABLE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            for (k = held; k > pos; k--) begin
              tab_base[k]  = tab_base[k-1];
              tab_limit[k] = tab_limit[k-1];
              tab_flags[k] = tab_flags[k-1];
            end
            tab_base[pos]  = r.range_start;
            tab_limit[pos] = r.range_end;
            tab_flags[pos] = r.range_flags;
            held++;
          end
        end
      end
      CMD_FIND: begin
        hit = cache_v && cache_base <= r.lookup_address && r.lookup_address < cache_limit;
        for (k = 0; k < held && !hit; k++) begin
          if (tab_base[k] <= r.lookup_address && r.lookup_address < tab_limit[k]) begin
            hit = 1'b1;
            cache_v = 1'b1;
            cache_base = tab_base[k];
            cache_limit = tab_limit[k];
            cache_flags = tab_flags[k];
          end
        end
        if (hit) begin
          o.hit_start = cache_base;
          o.hit_end = cache_limit;
          o.hit_flags = cache_flags;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    o.entry_count = held[COUNT_W-1:0];
    return o;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  task automatic add_item(input logic [1:0] c, input logic [ADDR_W-1:0] s,
                          input logic [ADDR_W-1:0] e, input logic [FLAG_W-1:0] f,
                          input logic [ADDR_W-1:0] a, input bit drain);
    req_t r;
    r.command = c;
    r.range_start = s;
    r.range_end = e;
    r.range_flags = f;
    r.lookup_address = a;
    pending_reqs.push_back(r);
    pending_drain.push_back(drain);
  endtask

  task automatic add_noise();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    add_item(w[1:0], rand_addr(), rand_addr(), w[5:2], rand_addr(), 1'b0);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // stimulus
  task automatic build_stimulus();
    int n_rand;
    int n_ops;
    int n_slots;
    int i;
    int op;
    int sh;
    int unsigned span;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;

    add_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, '0, 1'b0);
    add_item(CMD_INSERT, 39'h40, 39'h40, 4'hF, '0, 1'b0);
    add_item(CMD_INSERT, ADDR_TOP, '0, 4'hF, '0, 1'b0);
    add_item(CMD_INSERT, 39'h100, 39'h200, 4'hF, '0, 1'b0);
    add_item(CMD_INSERT, 39'h100, 39'h180, 4'h1, '0, 1'b0);
    add_item(CMD_INSERT, 39'h080, 39'h101, 4'h2, '0, 1'b0);
    add_item(CMD_INSERT, 39'h1FF, 39'h300, 4'h3, '0, 1'b0);
    add_item(CMD_INSERT, 39'h200, 39'h300, 4'h0, '0, 1'b0);
    add_item(CMD_INSERT, 39'h000, 39'h100, 4'h5, '0, 1'b0);
    add_item(CMD_INSERT, ADDR_TOP - 39'hFF, ADDR_TOP, 4'hA, '0, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, ADDR_TOP - 39'd1, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, ADDR_TOP, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, 39'h150, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, 39'h1FF, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, 39'h000, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, 39'h300, 1'b0);
    add_item(CMD_UNUSED, ADDR_TOP, ADDR_TOP, 4'hF, ADDR_TOP, 1'b0);
    add_item(CMD_CLEAR, ADDR_TOP, ADDR_TOP, 4'hF, ADDR_TOP, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, 39'h150, 1'b0);
    add_item(CMD_INSERT, '0, ADDR_TOP, 4'h9, '0, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, ADDR_TOP - 39'd1, 1'b0);
    add_item(CMD_FIND, '0, '0, '0, '0, 1'b0);
    add_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(99) < 8) begin
        n_ops = $urandom_range(12, 4);
        for (i = 0; i < n_ops; i++) add_noise();
        n_rand += n_ops;
      end else begin
        // one table session: ranges laid out in slots of a random region
        if ($urandom_range(99) < 85)
          add_item(CMD_CLEAR, rand_addr(), rand_addr(), FLAG_W'($urandom()), rand_addr(),
                   n_rand == 0 || $urandom_range(99) < 4);
        base = rand_addr();
        sh = $urandom_range(30, 2);
        slot = 39'd1 << sh;
        span = 32'd1 << sh;
        n_slots = $urandom_range(24, 4);
        n_ops = $urandom_range(60, 10);
        for (op = 0; op < n_ops; op++) begin
          i = $urandom_range(n_slots - 1);
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: begin
              s = base + slot * i + $urandom_range(span / 4);
              e = s + 39'd1 + $urandom_range(span / 2);
              add_item(CMD_INSERT, s, e, FLAG_W'($urandom()), rand_addr(), 1'b0);
            end
            9: begin
              s = base + slot * i + $urandom_range(span);
              e = s - $urandom_range(3);
              add_item(CMD_INSERT, s, e, FLAG_W'($urandom()), rand_addr(), 1'b0);
            end
            10: begin
              s = base + slot * i + slot / 2 + $urandom_range(span / 2);
              e = s + slot;
              add_item(CMD_INSERT, s, e, FLAG_W'($urandom()), rand_addr(), 1'b0);
            end
            11: add_noise();
            12: add_item(CMD_FIND, rand_addr(), rand_addr(), FLAG_W'($urandom()),
                         rand_addr(), 1'b0);
            default: begin
              s = base + slot * i + $urandom_range(span - 1);
              add_item(CMD_FIND, rand_addr(), rand_addr(), FLAG_W'($urandom()), s, 1'b0);
            end
          endcase
        end
        n_rand += n_ops + 1;
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst && !(req_valid && n_acc != n_issued)) begin
      drv_valid = 1'b0;
      if (pending_reqs.size() > 0 && !(pending_drain[0] && expected_rsps.size() != 0)) begin
        if ((n_acc >= 700 && n_acc < 900) || $urandom_range(99) >= 29) begin
          drv_item = pending_reqs.pop_front();
          void'(pending_drain.pop_front());
          drv_valid = 1'b1;
          n_issued++;
          req <= drv_item;
        end
      end
      req_valid <= drv_valid;
    end
  end

  // response side ready
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && n_acc >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= (n_acc >= 700 && n_acc < 900) || $urandom_range(99) >= 29;
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(table_apply(req));
        n_acc++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no command outstanding: %0h", rsp);
          fails++;
        end else begin
          check_field("status", expected_rsps[0].status, rsp.status);
          check_field("hit_start", expected_rsps[0].hit_start, rsp.hit_start);
          check_field("hit_end", expected_rsps[0].hit_end, rsp.hit_end);
          check_field("hit_flags", expected_rsps[0].hit_flags, rsp.hit_flags);
          check_field("entry_count", expected_rsps[0].entry_count, rsp.entry_count);
          void'(expected_rsps.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** region_interval_table: FAILED **");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && n_acc == n_issued);
    wait (expected_rsps.size() == 0);
    repeat (TABLE_DEPTH + 20) @(posedge clk);
    if (fails == 0 && expected_rsps.size() == 0) begin
      $display("** region_interval_table: PASSED **");
    end else begin
      $display("** region_interval_table: FAILED **");
    end
    $finish;
  end

endmodule
